// File: rtl/des_pkg.sv
// ----------------------------------------------------------------------------
// DES package
// Bit permutation tables, S-boxes, item codes and controller/datapath types.
// ----------------------------------------------------------------------------
package des_pkg;

	localparam int KEY_SLOTS  = 16;
	localparam int IDX_W      = 4;
	localparam int RKEY_W     = 48;
	localparam int BLK_W      = 64;
	localparam int HALF_W     = 32;
	localparam int KIND_W     = 2;
	localparam int S_TDATA_W  = 120;
	localparam int M_TDATA_W  = 64;

	localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENCRYPT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DECRYPT = 2'd2;

	localparam logic [IDX_W-1:0] LAST_ROUND = 4'd15;

	typedef struct packed {
		logic load;     // write round key store
		logic start;    // load IP(block), fetch first key
		logic decrypt;  // key order for the request being started
		logic round;    // run one Feistel round
		logic finish;   // capture FP result into output register
	} des_cmd_t;

	typedef struct packed {
		logic last_round;
	} des_sts_t;

	// Entries are 1-based source bit positions, MSB first.
	localparam logic [6:0] IP_TAB [64] = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7
	};

	localparam logic [6:0] FP_TAB [64] = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25
	};

	localparam logic [5:0] E_TAB [48] = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
		28,29,30,31,32,1
	};

	localparam logic [5:0] P_TAB [32] = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25
	};

	localparam logic [3:0] S_TAB [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
		  0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
		  15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
		  3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
		  13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
		  13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
		  1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
		  13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
		  3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
		  14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
		  11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
		  10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
		  4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
		  13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
		  6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
		  1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
		  2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}
	};

	function automatic logic [BLK_W-1:0] ip_perm(input logic [BLK_W-1:0] v);
		logic [BLK_W-1:0] r;
		r = '0;
		for (int k = 0; k < BLK_W; k++) begin
			r[BLK_W-1-k] = v[6'(7'(BLK_W) - IP_TAB[k])];
		end
		return r;
	endfunction

	function automatic logic [BLK_W-1:0] fp_perm(input logic [BLK_W-1:0] v);
		logic [BLK_W-1:0] r;
		r = '0;
		for (int k = 0; k < BLK_W; k++) begin
			r[BLK_W-1-k] = v[6'(7'(BLK_W) - FP_TAB[k])];
		end
		return r;
	endfunction

	// f function: E expansion, key mix, S-boxes, P permutation
	function automatic logic [HALF_W-1:0] feistel(input logic [HALF_W-1:0] r,
	                                              input logic [RKEY_W-1:0] k);
		logic [RKEY_W-1:0] x;
		logic [HALF_W-1:0] s;
		logic [HALF_W-1:0] p;
		logic [5:0]        six;
		x = '0;
		s = '0;
		p = '0;
		for (int i = 0; i < RKEY_W; i++) begin
			x[RKEY_W-1-i] = r[5'(6'(HALF_W) - E_TAB[i])];
		end
		x = x ^ k;
		for (int b = 0; b < 8; b++) begin
			six = x[RKEY_W-1-6*b -: 6];
			s[HALF_W-1-4*b -: 4] = S_TAB[b][{six[5], six[0], six[4:1]}];
		end
		for (int i = 0; i < HALF_W; i++) begin
			p[HALF_W-1-i] = s[5'(6'(HALF_W) - P_TAB[i])];
		end
		return p;
	endfunction

endpackage

// File: rtl/des_ctrl.sv
// ----------------------------------------------------------------------------
// DES controller
// Sequences load, sixteen rounds and result capture; owns output valid.
// ----------------------------------------------------------------------------
module des_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [des_pkg::KIND_W-1:0] in_kind,
	output logic                      out_valid,
	input  logic                      out_ready,
	output des_pkg::des_cmd_t         cmd,
	input  des_pkg::des_sts_t         sts
);
	import des_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ROUND  = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.decrypt = (in_kind == KIND_DECRYPT);
		state_d     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load  = accept && (in_kind == KIND_LOAD);
				cmd.start = accept && ((in_kind == KIND_ENCRYPT) || (in_kind == KIND_DECRYPT));
				if (cmd.start) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (sts.last_round) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// wait for the output register to drain
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result captured over an untaken result");

	a_start_round: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_ROUND))
		else $error("start did not enter round state");

	a_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.round && sts.last_round) |=> (state_q == ST_FINISH))
		else $error("round sequence did not end after last round");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND || state_q == ST_FINISH) |-> !(cmd.load || cmd.start))
		else $error("request taken while busy");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("result not presented after capture");
`endif

endmodule

// File: rtl/des_datapath.sv
// ----------------------------------------------------------------------------
// DES datapath
// Round key store, L/R halves with one shared round unit, output register.
// ----------------------------------------------------------------------------
module des_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  des_pkg::des_cmd_t                cmd,
	output des_pkg::des_sts_t                sts,
	input  logic [des_pkg::IDX_W-1:0]        key_index,
	input  logic [des_pkg::RKEY_W-1:0]       round_key,
	input  logic [des_pkg::BLK_W-1:0]        block_in,
	output logic [des_pkg::BLK_W-1:0]        block_out
);
	import des_pkg::*;

	logic [RKEY_W-1:0] key_mem [KEY_SLOTS];
	logic [RKEY_W-1:0] key_q;
	logic [HALF_W-1:0] left_q;
	logic [HALF_W-1:0] right_q;
	logic [IDX_W-1:0]  count_q;
	logic              dec_q;
	logic [IDX_W-1:0]  rd_idx;
	logic [IDX_W-1:0]  rd_addr;
	logic              rd_dec;
	logic [BLK_W-1:0]  ip_val;
	logic [BLK_W-1:0]  out_q;

	assign sts.last_round = (count_q == LAST_ROUND);
	assign ip_val         = ip_perm(block_in);

	// key for the next round is registered into key_q ahead of it; decrypt reverses order
	assign rd_idx  = cmd.start ? '0 : (count_q + 1'b1);
	assign rd_dec  = cmd.start ? cmd.decrypt : dec_q;
	assign rd_addr = rd_dec ? ~rd_idx : rd_idx;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_mem[key_index] <= round_key;
		end
		key_q <= key_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dec_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				count_q <= '0;
				dec_q   <= cmd.decrypt;
			end else if (cmd.round) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			left_q  <= ip_val[BLK_W-1 -: HALF_W];
			right_q <= ip_val[HALF_W-1:0];
		end else if (cmd.round) begin
			left_q  <= right_q;
			right_q <= left_q ^ feistel(right_q, key_q);
		end
		if (cmd.finish) begin
			out_q <= fp_perm({right_q, left_q});
		end
	end

	assign block_out = out_q;

endmodule

// File: rtl/des_block_cipher.sv
// An accepted encrypt/decrypt request is taken through IP load, the rounds and
// the result capture; the single round unit runs the 16 rounds one per clock,
// and no request is taken until capture; key loads do not start the rounds.
// A finished result waits in the output register while the next request runs.
// Reset (arst_n low, asynchronous) idles the controller and empties the output;
// the round key store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// DES block cipher top level
// ECB DES with externally loaded round keys; controller plus datapath.
// ----------------------------------------------------------------------------
module des_block_cipher (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [3:0] key_index, [51:4] round_key, [115:52] block_in, [119:116] zero
	input  logic [des_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// [1:0] kind
	input  logic [des_pkg::KIND_W-1:0]        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [63:0] block_out
	output logic [des_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
	import des_pkg::*;

	des_cmd_t cmd;
	des_sts_t sts;

	des_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	des_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.key_index (s_axis_tdata[IDX_W-1:0]),
		.round_key (s_axis_tdata[IDX_W+RKEY_W-1:IDX_W]),
		.block_in  (s_axis_tdata[IDX_W+RKEY_W+BLK_W-1:IDX_W+RKEY_W]),
		.block_out (m_axis_tdata)
	);

endmodule

// File: test/des_block_cipher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES block cipher testbench
// Streams round key loads, encrypt and decrypt requests and unused-kind
// requests into the cipher with random gaps and output stalls. Each returned
// block is compared against a behavioral DES computed from the loaded keys.
// ----------------------------------------------------------------------------
module des_block_cipher_test;
	import des_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_REQS = 580;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  key_index;
		logic [RKEY_W-1:0] round_key;
		logic [BLK_W-1:0]  block_in;
		bit                drain_first;  // hold until all blocks are back
		bit                steady;       // never idle before this request
	} des_req_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [KIND_W-1:0]    s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	des_req_t          pending_reqs[$];
	logic [BLK_W-1:0]  expected_blocks[$];
	logic [RKEY_W-1:0] key_copy [KEY_SLOTS];

	des_req_t          next_req;
	logic [BLK_W-1:0]  want_block;
	int                mismatches = 0;
	int                results_seen = 0;
	int                quiet_cycles = 0;
	int                loads_done = 0;
	int                encrypts_done = 0;
	int                decrypts_done = 0;
	int                unused_done = 0;

	des_block_cipher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// f function: expand, mix key, S-box substitute, P permute
	function automatic logic [HALF_W-1:0] round_mix(input logic [HALF_W-1:0] r,
	                                                input logic [RKEY_W-1:0] k);
		logic [RKEY_W-1:0] x;
		logic [HALF_W-1:0] s;
		logic [HALF_W-1:0] p;
		logic [5:0]        six;
		int                row;
		int                col;
		for (int i = 0; i < RKEY_W; i++)
			x[RKEY_W - 1 - i] = r[HALF_W - int'(E_TAB[i])];
		x = x ^ k;
		for (int b = 0; b < 8; b++) begin
			six = x[RKEY_W - 1 - 6 * b -: 6];
			row = 2 * int'(six[5]) + int'(six[0]);
			col = int'(six[4:1]);
			s[HALF_W - 1 - 4 * b -: 4] = S_TAB[b][row * 16 + col];
		end
		for (int i = 0; i < HALF_W; i++)
			p[HALF_W - 1 - i] = s[HALF_W - int'(P_TAB[i])];
		return p;
	endfunction

	function automatic logic [BLK_W-1:0] des_transform(input logic [BLK_W-1:0] blk,
	                                                   input bit decrypt);
		logic [BLK_W-1:0]  t;
		logic [BLK_W-1:0]  o;
		logic [HALF_W-1:0] l;
		logic [HALF_W-1:0] r;
		logic [HALF_W-1:0] nr;
		for (int k = 0; k < BLK_W; k++)
			t[BLK_W - 1 - k] = blk[BLK_W - int'(IP_TAB[k])];
		l = t[BLK_W-1:HALF_W];
		r = t[HALF_W-1:0];
		for (int n = 0; n < KEY_SLOTS; n++) begin
			nr = l ^ round_mix(r, key_copy[decrypt ? KEY_SLOTS - 1 - n : n]);
			l = r;
			r = nr;
		end
		t = {r, l};
		for (int k = 0; k < BLK_W; k++)
			o[BLK_W - 1 - k] = t[BLK_W - int'(FP_TAB[k])];
		return o;
	endfunction

	function automatic void queue_req(input logic [KIND_W-1:0] kind,
	                                  input logic [IDX_W-1:0] idx,
	                                  input logic [RKEY_W-1:0] rkey,
	                                  input logic [BLK_W-1:0] blk,
	                                  input bit drain_first, input bit steady);
		des_req_t req;
		req.kind        = kind;
		req.key_index   = idx;
		req.round_key   = rkey;
		req.block_in    = blk;
		req.drain_first = drain_first;
		req.steady      = steady;
		pending_reqs.push_back(req);
	endfunction

	function automatic logic [BLK_W-1:0] rand_block();
		return {$urandom, $urandom};
	endfunction

	// Track an accepted request: update key copy or queue the expected block.
	task automatic absorb_request(input logic [KIND_W-1:0] kind,
	                              input logic [S_TDATA_W-1:0] data);
		case (kind)
			KIND_LOAD: begin
				key_copy[data[3:0]] = data[51:4];
				loads_done++;
			end
			KIND_ENCRYPT: begin
				expected_blocks.push_back(des_transform(data[115:52], 1'b0));
				encrypts_done++;
			end
			KIND_DECRYPT: begin
				expected_blocks.push_back(des_transform(data[115:52], 1'b1));
				decrypts_done++;
			end
			default: unused_done++;
		endcase
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				absorb_request(s_axis_tuser, s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_reqs.size() != 0
				    && (pending_reqs[0].steady || $urandom_range(99) >= 23)
				    && !(pending_reqs[0].drain_first && expected_blocks.size() != 0)) begin
					next_req = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= next_req.kind;
					s_axis_tdata  <= {4'b0, next_req.block_in, next_req.round_key,
					                  next_req.key_index};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_blocks.size() == 0) begin
					$error("block_out: expected none, got %h", m_axis_tdata);
					mismatches++;
				end else begin
					want_block = expected_blocks.pop_front();
					if (m_axis_tdata !== want_block) begin
						$error("block_out: expected %h, got %h", want_block, m_axis_tdata);
						mismatches++;
					end
				end
				results_seen++;
			end
			// results 120..199 see no backpressure
			m_axis_tready <= (results_seen >= 120 && results_seen < 200)
			                 || ($urandom_range(99) >= 23);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
		$display("des_block_cipher: mismatch");
		$finish;
	end

	initial begin
		int real_reqs;
		int pick;
		real_reqs = 0;

		// Fill every key slot first; zero key, all-ones key and random keys.
		for (int i = 0; i < KEY_SLOTS; i++)
			queue_req(KIND_LOAD, IDX_W'(i),
			          (i == 0) ? '0 : (i == KEY_SLOTS - 1) ? '1 : RKEY_W'(rand_block()),
			          (i % 2 == 0) ? '1 : rand_block(), 1'b0, 1'b0);
		queue_req(KIND_ENCRYPT, '0, '0, '0, 1'b0, 1'b0);
		queue_req(KIND_ENCRYPT, '1, '1, '1, 1'b0, 1'b0);
		queue_req(KIND_DECRYPT, '0, '0, '0, 1'b0, 1'b0);
		queue_req(KIND_DECRYPT, '1, '1, '1, 1'b0, 1'b0);
		queue_req(KIND_UNUSED, '1, '1, '1, 1'b0, 1'b0);
		queue_req(KIND_UNUSED, 4'd5, RKEY_W'(rand_block()), rand_block(), 1'b0, 1'b0);
		queue_req(KIND_ENCRYPT, 4'd3, RKEY_W'(rand_block()), rand_block(), 1'b1, 1'b0);
		// key rewrite right behind a block in flight
		queue_req(KIND_LOAD, 4'd7, RKEY_W'(rand_block()), rand_block(), 1'b0, 1'b1);
		queue_req(KIND_DECRYPT, 4'd9, RKEY_W'(rand_block()), rand_block(), 1'b0, 1'b1);

		while (real_reqs < RANDOM_REQS) begin
			pick = $urandom_range(99);
			if (pick < 92) begin
				queue_req((pick < 12) ? KIND_LOAD : (pick < 52) ? KIND_ENCRYPT : KIND_DECRYPT,
				          IDX_W'($urandom_range(15)), RKEY_W'(rand_block()), rand_block(),
				          (real_reqs % 150) == 149, real_reqs >= 300 && real_reqs < 420);
				real_reqs++;
			end else begin
				queue_req(KIND_UNUSED, IDX_W'($urandom_range(15)), RKEY_W'(rand_block()),
				          rand_block(), 1'b0, 1'b0);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || s_axis_tvalid || expected_blocks.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_blocks.size() != 0) begin
			$error("block_out: %0d expected blocks never arrived", expected_blocks.size());
			mismatches++;
		end

		$display("covered %0d key loads, %0d encrypts, %0d decrypts, %0d unused-kind requests",
		         loads_done, encrypts_done, decrypts_done, unused_done);
		$display("checked %0d output blocks, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("des_block_cipher: match");
		else
			$display("des_block_cipher: mismatch");
		$finish;
	end

endmodule
